[hw/rtl/lpht_pkg.sv]
// lpht_pkg: shared constants, codes and types of the linear probe hash table
package lpht_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

  localparam int FUNC_W  = 2;
  localparam int KEY_W   = 31;
  localparam int PAY_W   = 64;
  localparam int STAT_W  = 3;
  localparam int SLOTF_W = 4;
  localparam int BIT_W   = $clog2(KEY_W);

  typedef logic [SLOT_W-1:0] idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [PAY_W-1:0]  pay_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_SEARCH = 2'd1,
    FN_REMOVE = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_REMOVED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic valid;
    key_t key;
    pay_t payload;
  } entry_t;

  typedef struct packed {
    logic   we;
    idx_t   addr;
    entry_t data;
  } wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } rd_req_t;

endpackage

[hw/rtl/lpht_if.sv]
// lpht_if: valid/ready channel interfaces for operations and results
interface lpht_in_if;
  import lpht_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [KEY_W-1:0]    key;
  logic [PAY_W-1:0]    payload;

  modport source (output valid, func, key, payload, input ready);
  modport sink   (input valid, func, key, payload, output ready);
endinterface

interface lpht_out_if;
  import lpht_pkg::*;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [SLOTF_W-1:0]  slot;
  logic [PAY_W-1:0]    found_payload;

  modport source (output valid, status, slot, found_payload, input ready);
  modport sink   (input valid, status, slot, found_payload, output ready);
endinterface

[hw/rtl/linear_probe_hash_table_core.sv]
// linear_probe_hash_table_core: open addressing table with linear probing
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   func, key, payload
//   out_ch   out  valid/ready   status, slot, found_payload
//
// one operation at a time: accept, SLOTS reads from the slot memory (one per
// cycle, probe from the home slot), compare of the last read and exit from the
// scan, then write-back and result; for a slot count that is not a power of two
// a bit-serial home slot remainder over the KEY_W key bits comes before the
// scan.
// after reset a clearing pass writes every slot, with in_ch not ready. a
// stalled out_ch holds the result register; the next operation is taken and
// scanned meanwhile and waits at write-back until the result leaves.
module linear_probe_hash_table_core
  import lpht_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lpht_in_if.sink    in_ch,
  lpht_out_if.source out_ch
);

  wr_t     wr;
  rd_req_t rd;
  entry_t  rd_q;

  lpht_store u_store (
    .clk  (clk),
    .wr   (wr),
    .rd   (rd),
    .rd_q (rd_q)
  );

  lpht_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .wr     (wr),
    .rd     (rd),
    .rd_q   (rd_q)
  );

endmodule

[hw/rtl/lpht_store.sv]
// lpht_store: slot memory holding valid bit, key and payload, registered read
module lpht_store
  import lpht_pkg::*;
(
  input  logic    clk,
  input  wr_t     wr,
  input  rd_req_t rd,
  output entry_t  rd_q
);

  entry_t mem [SLOTS];
  entry_t rd_q_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_q_r <= mem[rd.addr];
    end
  end

  assign rd_q = rd_q_r;

endmodule

[hw/rtl/lpht_ctrl.sv]
// lpht_ctrl: home slot unit, probe sequencer, write-back and result register
module lpht_ctrl
  import lpht_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  lpht_in_if.sink       in_ch,
  lpht_out_if.source    out_ch,
  output wr_t           wr,
  output rd_req_t       rd,
  input  entry_t        rd_q
);

  state_t state_r, state_nxt;
  idx_t   clr_r, clr_nxt;
  logic   out_vld_r, out_vld_nxt;

  logic [FUNC_W-1:0]  func_r, func_nxt;
  key_t               key_r, key_nxt;
  pay_t               pay_r, pay_nxt;
  key_t               ksh_r, ksh_nxt;
  logic [BIT_W-1:0]   bitcnt_r, bitcnt_nxt;
  idx_t               rem_r, rem_nxt;
  idx_t               pos_r, pos_nxt;
  cnt_t               cnt_r, cnt_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  idx_t               cmp_addr_r, cmp_addr_nxt;
  logic               hit_r, hit_nxt;
  idx_t               hit_idx_r, hit_idx_nxt;
  pay_t               hit_pay_r, hit_pay_nxt;
  logic               empty_r, empty_nxt;
  idx_t               empty_idx_r, empty_idx_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [SLOTF_W-1:0] out_slot_r, out_slot_nxt;
  pay_t               out_fpay_r, out_fpay_nxt;

  logic [SLOT_W:0] home_t;
  idx_t            home_red;
  logic            hit_now;
  logic            empty_now;
  logic            out_free;

  // one remainder bit per cycle, msb of key first
  assign home_t   = {rem_r, ksh_r[KEY_W-1]};
  assign home_red = (home_t >= (SLOT_W+1)'(SLOTS)) ?
                    SLOT_W'(home_t - (SLOT_W+1)'(SLOTS)) : SLOT_W'(home_t);

  assign hit_now   = cmp_vld_r && rd_q.valid && (rd_q.key == key_r);
  assign empty_now = cmp_vld_r && !rd_q.valid;
  assign out_free  = !out_vld_r || out_ch.ready;

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_vld_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.slot          = out_slot_r;
  assign out_ch.found_payload = out_fpay_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    out_vld_nxt    = out_vld_r && !out_ch.ready;
    func_nxt       = func_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    ksh_nxt        = ksh_r;
    bitcnt_nxt     = bitcnt_r;
    rem_nxt        = rem_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    cmp_vld_nxt    = 1'b0;
    cmp_addr_nxt   = cmp_addr_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_pay_nxt    = hit_pay_r;
    empty_nxt      = empty_r;
    empty_idx_nxt  = empty_idx_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_fpay_nxt   = out_fpay_r;
    wr             = '0;
    rd             = '0;

    unique case (state_r)
      S_CLEAR: begin
        wr.we   = 1'b1;
        wr.addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt   = in_ch.func;
          key_nxt    = in_ch.key;
          pay_nxt    = in_ch.payload;
          ksh_nxt    = in_ch.key;
          rem_nxt    = '0;
          bitcnt_nxt = BIT_W'(KEY_W - 1);
          cnt_nxt    = '0;
          hit_nxt    = 1'b0;
          empty_nxt  = 1'b0;
          if (SLOTS_POW2) begin
            pos_nxt   = in_ch.key[SLOT_W-1:0];
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_HOME;
          end
        end
      end
      S_HOME: begin
        rem_nxt    = home_red;
        ksh_nxt    = {ksh_r[KEY_W-2:0], 1'b0};
        bitcnt_nxt = bitcnt_r - 1'b1;
        if (bitcnt_r == '0) begin
          pos_nxt   = home_red;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // read issued here is compared in the following cycle
        if (cnt_r < CNT_W'(SLOTS)) begin
          rd.en        = 1'b1;
          rd.addr      = pos_r;
          cmp_vld_nxt  = 1'b1;
          cmp_addr_nxt = pos_r;
          cnt_nxt      = cnt_r + 1'b1;
          pos_nxt      = (pos_r == SLOT_W'(SLOTS - 1)) ? '0 : pos_r + 1'b1;
        end else if (!cmp_vld_r) begin
          state_nxt = S_DONE;
        end
        if (hit_now && !hit_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_addr_r;
          hit_pay_nxt = rd_q.payload;
        end
        if (empty_now && !empty_r) begin
          empty_nxt     = 1'b1;
          empty_idx_nxt = cmp_addr_r;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = ST_NOT_FOUND;
          out_slot_nxt   = '0;
          out_fpay_nxt   = '0;
          state_nxt      = S_IDLE;
          unique case (func_r)
            FN_INSERT: begin
              if (hit_r) begin
                out_status_nxt = ST_DUPLICATE;
              end else if (empty_r) begin
                wr.we              = 1'b1;
                wr.addr            = empty_idx_r;
                wr.data.valid      = 1'b1;
                wr.data.key        = key_r;
                wr.data.payload    = pay_r;
                out_status_nxt     = ST_INSERTED;
                out_slot_nxt       = SLOTF_W'(empty_idx_r);
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            FN_SEARCH: begin
              if (hit_r) begin
                out_status_nxt = ST_FOUND;
                out_slot_nxt   = SLOTF_W'(hit_idx_r);
                out_fpay_nxt   = hit_pay_r;
              end
            end
            FN_REMOVE: begin
              if (hit_r) begin
                wr.we          = 1'b1;
                wr.addr        = hit_idx_r;
                wr.data.valid  = 1'b0;
                wr.data.key    = key_r;
                out_status_nxt = ST_REMOVED;
                out_slot_nxt   = SLOTF_W'(hit_idx_r);
              end
            end
            default: begin
              out_status_nxt = ST_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    ksh_r        <= ksh_nxt;
    bitcnt_r     <= bitcnt_nxt;
    rem_r        <= rem_nxt;
    pos_r        <= pos_nxt;
    cnt_r        <= cnt_nxt;
    cmp_vld_r    <= cmp_vld_nxt;
    cmp_addr_r   <= cmp_addr_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_pay_r    <= hit_pay_nxt;
    empty_r      <= empty_nxt;
    empty_idx_r  <= empty_idx_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_fpay_r   <= out_fpay_nxt;
  end

endmodule

[verif/lpht_checker.sv]
// lpht_checker: predicts table results from input transfers and checks the result channel
module lpht_checker
  import lpht_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [PAY_W-1:0]   in_payload,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [STAT_W-1:0]  out_status,
  input  logic [SLOTF_W-1:0] out_slot,
  input  logic [PAY_W-1:0]   out_found_payload,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOTF_W-1:0] slot;
    pay_t               found_payload;
  } table_result_t;

  logic          occupied       [SLOTS];
  key_t          stored_key     [SLOTS];
  pay_t          stored_payload [SLOTS];
  table_result_t expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // full scan from the home slot, then apply the operation to the shadow table
  function automatic table_result_t probe_table(logic [FUNC_W-1:0] func, key_t key,
                                                pay_t payload);
    table_result_t r;
    idx_t          pos;
    int            hit;
    int            empty;
    r.status        = ST_NOT_FOUND;
    r.slot          = '0;
    r.found_payload = '0;
    hit             = -1;
    empty           = -1;
    if (func == FN_INSERT || func == FN_SEARCH || func == FN_REMOVE) begin
      pos = idx_t'(key % SLOTS);
      for (int i = 0; i < SLOTS; i++) begin
        if (occupied[pos]) begin
          if (hit < 0 && stored_key[pos] == key) hit = int'(pos);
        end else if (empty < 0) begin
          empty = int'(pos);
        end
        pos = (int'(pos) == SLOTS - 1) ? idx_t'(0) : idx_t'(pos + 1'b1);
      end
      case (func)
        FN_INSERT: begin
          if (hit >= 0) begin
            r.status = ST_DUPLICATE;
          end else if (empty >= 0) begin
            occupied[empty]       = 1'b1;
            stored_key[empty]     = key;
            stored_payload[empty] = payload;
            r.status              = ST_INSERTED;
            r.slot                = SLOTF_W'(empty);
          end else begin
            r.status = ST_FULL;
          end
        end
        FN_SEARCH: begin
          if (hit >= 0) begin
            r.status        = ST_FOUND;
            r.slot          = SLOTF_W'(hit);
            r.found_payload = stored_payload[hit];
          end
        end
        default: begin
          if (hit >= 0) begin
            occupied[hit] = 1'b0;
            r.status      = ST_REMOVED;
            r.slot        = SLOTF_W'(hit);
          end
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) occupied[i] = 1'b0;
      expected_results.delete();
    end else begin
      // result transfer first: it can never belong to an operation taken at this edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no operation outstanding: status %0d slot %0d",
                 out_status, out_slot);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
          if (out_slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, out_slot);
            fail_count++;
          end
          if (out_found_payload !== want.found_payload) begin
            $error("found_payload: expected %h, actual %h", want.found_payload,
                   out_found_payload);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(probe_table(in_func, in_key, in_payload));
    end
    pending = expected_results.size();
  end

endmodule

[verif/tb_top.sv]
// tb_top: stimulus, clock, reset and verdict for the linear probe hash table core
module tb_top;
  import lpht_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED   = 2'd3;
  localparam int                RAND_OPS    = 1700;
  localparam int                POOL_SIZE   = 20;
  localparam int                POOL_PERIOD = 250;
  localparam int                DRAIN_CYCLES = 2 * (SLOTS + 3) + 2;
  localparam int                CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  bit   burst;
  key_t key_pool [POOL_SIZE];
  bit   planted [key_t];

  lpht_in_if  in_ch ();
  lpht_out_if out_ch ();

  linear_probe_hash_table_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lpht_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_func           (in_ch.func),
    .in_key            (in_ch.key),
    .in_payload        (in_ch.payload),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_slot          (out_ch.slot),
    .out_found_payload (out_ch.found_payload),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one operation: optional gap, then hold valid until the transfer
  task automatic send_op(input logic [FUNC_W-1:0] f, input key_t k, input pay_t p);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= f;
    in_ch.key     <= k;
    in_ch.payload <= p;
    if (f == FN_INSERT) planted[k] = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic pay_t rand_payload();
    return {$urandom, $urandom};
  endfunction

  // empties the table by removing every key inserted since the last clear
  task automatic clear_planted();
    foreach (planted[k]) send_op(FN_REMOVE, k, rand_payload());
    planted.delete();
  endtask

  task automatic refill_pool();
    key_t k;
    for (int i = 0; i < POOL_SIZE; i++) begin
      k = key_t'($urandom);
      // half the keys crowd around the wrap point
      if (i % 2 == 0) k[3:0] = 4'(13 + $urandom_range(0, 3));
      key_pool[i] = k;
    end
  endtask

  task automatic run_directed();
    send_op(FN_INSERT, key_t'(0), pay_t'(0));
    send_op(FN_INSERT, {KEY_W{1'b1}}, {PAY_W{1'b1}});
    send_op(FN_INSERT, key_t'(0), rand_payload());
    send_op(FN_SEARCH, {KEY_W{1'b1}}, rand_payload());
    send_op(FN_SEARCH, key_t'(12345), rand_payload());
    send_op(FN_UNUSED, key_t'(0), {PAY_W{1'b1}});
    send_op(FN_REMOVE, key_t'(0), rand_payload());
    send_op(FN_REMOVE, key_t'(0), rand_payload());
    // fill every slot from home slot 15 so the probe wraps
    for (int i = 1; i <= 15; i++)
      send_op(FN_INSERT, key_t'(16 * i + 15), rand_payload());
    send_op(FN_INSERT, key_t'(16 * 20 + 15), rand_payload());
    // clear an early slot, the later record must still be reachable
    send_op(FN_REMOVE, key_t'(16 * 1 + 15), rand_payload());
    send_op(FN_SEARCH, key_t'(16 * 5 + 15), rand_payload());
  endtask

  task automatic run_random();
    int   pick;
    key_t k;
    for (int n = 0; n < RAND_OPS; n++) begin
      if (n % POOL_PERIOD == 0) begin
        burst = 1'b0;
        clear_planted();
        refill_pool();
      end
      burst = ((n / 150) % 3) == 1;
      pick  = $urandom_range(0, 99);
      k     = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 45) begin
        send_op(FN_INSERT, k, rand_payload());
      end else begin
        // stray keys only on lookups so the table never clogs
        if ($urandom_range(0, 9) == 0) k = key_t'($urandom);
        if (pick < 70)      send_op(FN_SEARCH, k, rand_payload());
        else if (pick < 95) send_op(FN_REMOVE, k, rand_payload());
        else                send_op(FN_UNUSED, k, rand_payload());
      end
    end
  endtask

  // result side: random stall before each result, then hold ready until the transfer
  initial begin
    int stall;
    forever begin
      stall = (burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  initial begin
    burst         = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.func    <= FN_INSERT;
    in_ch.key     <= '0;
    in_ch.payload <= '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    run_random();
    in_ch.valid <= 1'b0;
    burst = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_if.sv
hw/rtl/lpht_store.sv
hw/rtl/lpht_ctrl.sv
hw/rtl/linear_probe_hash_table_core.sv
verif/lpht_checker.sv
verif/tb_top.sv
